FILE: rtl/core/rgp_pkg.sv
// Shared types and constants of the range grid projection unit.
// Used by every module under rtl/core; depends on nothing.
`timescale 1ns / 1ps
package rgp_pkg;

  localparam int REG_W = 60;

  localparam logic [3:0] REG_COEFF_X   = 4'd0;
  localparam logic [3:0] REG_COEFF_Y   = 4'd1;
  localparam logic [3:0] REG_COEFF_W   = 4'd2;
  localparam logic [3:0] REG_OFFSETS   = 4'd3;
  localparam logic [3:0] REG_GRID_W    = 4'd4;
  localparam logic [3:0] REG_GRID_H    = 4'd5;
  localparam logic [3:0] REG_STEPS     = 4'd6;
  localparam logic [3:0] REG_MODE      = 4'd7;

  localparam int MODE_ORTHO_BIT = 0;
  localparam int MODE_INT_BIT   = 1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GRID,
    ST_MAC,
    ST_DIV,
    ST_HOLD
  } state_t;

  typedef struct packed {
    logic used;
    logic last;
  } grid_info_t;

endpackage

FILE: rtl/core/range_grid_projection_unit.sv
// Top level of the range grid projection unit: registers, sequencer, output beat.
// Depends on rgp_pkg, rgp_grid, rgp_mac and rgp_div.
`timescale 1ns / 1ps
// One depth sample is taken at a time. Every sample passes the bit-serial step
// test (CW = clog2(MAX_GRID_DIM), 12 by default); an unused sample, off the grid
// or off the step grid, ends there. A used sample then goes through the serial
// multiply-accumulate over M = max(CW + 1, 16) bits and, in perspective mode with
// a nonzero denominator, the shared two-lane divider on SW = M + COEFF_WIDTH + 6
// bit sums, and is loaded into the output register once that register is free
// (not holding a stalled beat). A finished result waits in the output register
// while the next sample is already being worked on.
module range_grid_projection_unit #(
  parameter int MAX_GRID_DIM = 4096,
  parameter int COEFF_WIDTH  = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic signed [15:0]        in_depth_sample,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        out_x_out,
  output logic signed [31:0]        out_y_out,
  output logic                      out_zero_denominator,
  output logic                      out_last_in_frame,
  input  logic                      cfg_we,
  input  logic [3:0]                cfg_index,
  input  logic [rgp_pkg::REG_W-1:0] cfg_data
);
  import rgp_pkg::*;

  localparam int CW = $clog2(MAX_GRID_DIM);
  localparam int M  = (CW + 1 > 16) ? CW + 1 : 16;
  localparam int SW = M + COEFF_WIDTH + 6;

  logic [REG_W-1:0] coeff_x_r, coeff_y_r, coeff_w_r, offsets_r;
  logic [12:0]      grid_w_r, grid_h_r;
  logic [15:0]      steps_r;
  logic [1:0]       mode_r;

  state_t state_r, state_nxt;
  logic   accept, mac_start, div_start, load_out;
  logic   grid_done, mac_done, div_done;
  grid_info_t info;
  logic [CW-1:0] g_col, g_row;
  logic signed [15:0] depth_r;
  logic   last_r;
  logic signed [SW-1:0] sum_x, sum_y, sum_w;
  logic [31:0] div_x, div_y, res_x, res_y, sx, sy;
  logic   w_zero, res_zden;

  logic        out_valid_r;
  logic [31:0] out_x_r, out_y_r;
  logic        out_zden_r, out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_x_r <= REG_W'(4096);
      coeff_y_r <= REG_W'(64'h1_0000_0000);
      coeff_w_r <= '0;
      offsets_r <= REG_W'(64'h400_0000_0000);
      grid_w_r  <= 13'd256;
      grid_h_r  <= 13'd256;
      steps_r   <= 16'd257;
      mode_r    <= 2'd0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_COEFF_X: coeff_x_r <= cfg_data;
        REG_COEFF_Y: coeff_y_r <= cfg_data;
        REG_COEFF_W: coeff_w_r <= cfg_data;
        REG_OFFSETS: offsets_r <= cfg_data;
        REG_GRID_W:  grid_w_r  <= cfg_data[12:0];
        REG_GRID_H:  grid_h_r  <= cfg_data[12:0];
        REG_STEPS:   steps_r   <= cfg_data[15:0];
        REG_MODE:    mode_r    <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  rgp_grid #(.MAX_GRID_DIM(MAX_GRID_DIM), .CW(CW)) u_grid (
    .clk(clk), .rst_n(rst_n), .start(accept),
    .grid_width(grid_w_r), .grid_height(grid_h_r), .step_sizes(steps_r),
    .done(grid_done), .info(info), .col(g_col), .row(g_row)
  );

  rgp_mac #(.CW(CW), .COEFF_WIDTH(COEFF_WIDTH), .SW(SW)) u_mac (
    .clk(clk), .rst_n(rst_n), .start(mac_start),
    .col(g_col), .row(g_row), .depth(depth_r),
    .coeff_x(coeff_x_r), .coeff_y(coeff_y_r), .coeff_w(coeff_w_r), .offsets(offsets_r),
    .done(mac_done), .sum_x(sum_x), .sum_y(sum_y), .sum_w(sum_w)
  );

  rgp_div #(.SW(SW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .frac(!mode_r[MODE_INT_BIT]),
    .num_x(sum_x), .num_y(sum_y), .den(sum_w),
    .done(div_done), .res_x(div_x), .res_y(div_y)
  );

  function automatic logic [31:0] sat32(input logic signed [SW-1:0] v);
    if (v[SW-1:31] == '0 || v[SW-1:31] == '1) return v[31:0];
    return v[SW-1] ? 32'h80000000 : 32'h7FFFFFFF;
  endfunction

  function automatic logic [31:0] trunc_int(input logic [31:0] v);
    if (v[31] && v[15:0] != 16'd0) return {v[31:16] + 16'd1, 16'd0};
    return {v[31:16], 16'd0};
  endfunction

  always_comb begin
    w_zero = (sum_w == '0);
    sx = sat32(sum_x);
    sy = sat32(sum_y);
    res_zden = 1'b0;
    if (mode_r[MODE_ORTHO_BIT]) begin
      res_x = mode_r[MODE_INT_BIT] ? trunc_int(sx) : sx;
      res_y = mode_r[MODE_INT_BIT] ? trunc_int(sy) : sy;
    end else if (w_zero) begin
      res_x    = '0;
      res_y    = '0;
      res_zden = 1'b1;
    end else begin
      res_x = div_x;
      res_y = div_y;
    end
  end

  always_comb begin
    state_nxt = state_r;
    mac_start = 1'b0;
    div_start = 1'b0;
    load_out  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (accept) state_nxt = ST_GRID;
      end
      ST_GRID: begin
        if (grid_done) begin
          if (info.used) begin
            mac_start = 1'b1;
            state_nxt = ST_MAC;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_MAC: begin
        if (mac_done) begin
          if (!mode_r[MODE_ORTHO_BIT] && !w_zero) begin
            div_start = 1'b1;
            state_nxt = ST_DIV;
          end else begin
            state_nxt = ST_HOLD;
          end
        end
      end
      ST_DIV: begin
        if (div_done) state_nxt = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) depth_r <= in_depth_sample;
    if (grid_done) last_r <= info.last;
    if (load_out) begin
      out_x_r    <= res_x;
      out_y_r    <= res_y;
      out_zden_r <= res_zden;
      out_last_r <= last_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_x_out            = out_x_r;
  assign out_y_out            = out_y_r;
  assign out_zero_denominator = out_zden_r;
  assign out_last_in_frame    = out_last_r;

  // A new beat only appears when the sequencer finishes an item.
  a_beat_from_hold: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_HOLD))
    else $error("output beat appeared without a finished item");

  // Orthographic items never occupy the divider.
  a_no_div_ortho: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> !mode_r[MODE_ORTHO_BIT])
    else $error("divider busy in orthographic mode");

  // A zero denominator beat carries zero coordinates.
  a_zden_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_zden_r) |-> (out_x_r == '0 && out_y_r == '0))
    else $error("zero denominator beat with nonzero coordinates");

  // A waiting result is not overwritten while the sink stalls.
  a_hold_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_HOLD && out_valid_r && out_stall) |=> (state_r == ST_HOLD))
    else $error("result left hold while the output beat was stalled");

endmodule

FILE: rtl/core/rgp_grid.sv
// Column and row counters with a bit-serial remainder unit for the step test.
// Depends on rgp_pkg.
`timescale 1ns / 1ps
module rgp_grid #(
  parameter int MAX_GRID_DIM = 4096,
  parameter int CW = 12
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [12:0]        grid_width,
  input  logic [12:0]        grid_height,
  input  logic [15:0]        step_sizes,
  output logic               done,
  output rgp_pkg::grid_info_t info,
  output logic [CW-1:0]      col,
  output logic [CW-1:0]      row
);
  import rgp_pkg::*;

  localparam int DW = CW + 1;
  localparam int BW = $clog2(CW + 1);

  logic [DW-1:0] weff, heff;
  logic [7:0]    xs, ys;
  logic [CW-1:0] cnt_col_r, cnt_row_r, col_r, row_r, sc_r, sr_r;
  logic [7:0]    remc_r, remr_r;
  logic [BW-1:0] bc_r;
  logic          busy_r, done_r;
  logic [DW-1:0] col_p1, row_p1;
  logic [8:0]    rc, rr;
  logic [DW+7:0] col_end, row_end;

  always_comb begin
    if (grid_width == 13'd0) begin
      weff = DW'(1);
    end else if ({19'd0, grid_width} > 32'(MAX_GRID_DIM)) begin
      weff = DW'(MAX_GRID_DIM);
    end else begin
      weff = DW'(grid_width);
    end
    if (grid_height == 13'd0) begin
      heff = DW'(1);
    end else if ({19'd0, grid_height} > 32'(MAX_GRID_DIM)) begin
      heff = DW'(MAX_GRID_DIM);
    end else begin
      heff = DW'(grid_height);
    end
    xs = (step_sizes[7:0] == 8'd0) ? 8'd1 : step_sizes[7:0];
    ys = (step_sizes[15:8] == 8'd0) ? 8'd1 : step_sizes[15:8];
    col_p1 = {1'b0, cnt_col_r} + DW'(1);
    row_p1 = {1'b0, cnt_row_r} + DW'(1);
    // One restoring remainder step per cycle, column and row side by side.
    rc = {remc_r, sc_r[CW-1]};
    if (rc >= {1'b0, xs}) begin
      rc = rc - {1'b0, xs};
    end
    rr = {remr_r, sr_r[CW-1]};
    if (rr >= {1'b0, ys}) begin
      rr = rr - {1'b0, ys};
    end
    col_end = (DW+8)'(col_r) + (DW+8)'(xs);
    row_end = (DW+8)'(row_r) + (DW+8)'(ys);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_col_r <= '0;
      cnt_row_r <= '0;
      busy_r    <= 1'b0;
      done_r    <= 1'b0;
      bc_r      <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (col_p1 >= weff) begin
          cnt_col_r <= '0;
          cnt_row_r <= (row_p1 >= heff) ? '0 : row_p1[CW-1:0];
        end else begin
          cnt_col_r <= col_p1[CW-1:0];
        end
        busy_r <= 1'b1;
        bc_r   <= '0;
      end else if (busy_r) begin
        bc_r <= bc_r + BW'(1);
        if (bc_r == BW'(CW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      col_r  <= cnt_col_r;
      row_r  <= cnt_row_r;
      sc_r   <= cnt_col_r;
      sr_r   <= cnt_row_r;
      remc_r <= '0;
      remr_r <= '0;
    end else if (busy_r) begin
      sc_r   <= sc_r << 1;
      sr_r   <= sr_r << 1;
      remc_r <= rc[7:0];
      remr_r <= rr[7:0];
    end
  end

  assign done = done_r;
  assign col  = col_r;
  assign row  = row_r;
  assign info.used = ({1'b0, col_r} < weff) && ({1'b0, row_r} < heff) &&
                     (remc_r == 8'd0) && (remr_r == 8'd0);
  // The last used point is the used one whose next multiple falls off the grid.
  assign info.last = (col_end >= (DW+8)'(weff)) && (row_end >= (DW+8)'(heff));

endmodule

FILE: rtl/core/rgp_mac.sv
// Bit-serial multiply-accumulate of the three matrix rows, MSB first.
// Depends on rgp_pkg.
`timescale 1ns / 1ps
module rgp_mac #(
  parameter int CW = 12,
  parameter int COEFF_WIDTH = 20,
  parameter int SW = 42
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [CW-1:0]               col,
  input  logic [CW-1:0]               row,
  input  logic signed [15:0]          depth,
  input  logic [rgp_pkg::REG_W-1:0]   coeff_x,
  input  logic [rgp_pkg::REG_W-1:0]   coeff_y,
  input  logic [rgp_pkg::REG_W-1:0]   coeff_w,
  input  logic [rgp_pkg::REG_W-1:0]   offsets,
  output logic                        done,
  output logic signed [SW-1:0]        sum_x,
  output logic signed [SW-1:0]        sum_y,
  output logic signed [SW-1:0]        sum_w
);
  import rgp_pkg::*;

  localparam int M  = (CW + 1 > 16) ? CW + 1 : 16;
  localparam int CE = 3 * COEFF_WIDTH;
  localparam int NB = $clog2(M + 1);

  logic [M-1:0]  m0_r, m1_r, m2_r;
  logic [NB-1:0] cnt_r;
  logic          busy_r, off_r, done_r;
  logic signed [SW-1:0] acc_x_r, acc_y_r, acc_w_r;
  logic signed [SW-1:0] tx, ty, tw;
  logic [CE-1:0] ex_x, ex_y, ex_w, ex_o;

  function automatic logic signed [SW-1:0] fld(input logic [CE-1:0] ex, input int k);
    logic signed [COEFF_WIDTH-1:0] c;
    c = $signed(ex[k*COEFF_WIDTH +: COEFF_WIDTH]);
    return SW'(c);
  endfunction

  function automatic logic signed [SW-1:0] lane_term(input logic [CE-1:0] ex,
                                                     input logic b0, input logic b1,
                                                     input logic b2);
    logic signed [SW-1:0] t;
    t = '0;
    if (b0) t = t + (fld(ex, 0) <<< 4);
    if (b1) t = t + (fld(ex, 1) <<< 4);
    if (b2) t = t + fld(ex, 2);
    return t;
  endfunction

  always_comb begin
    ex_x = CE'(coeff_x);
    ex_y = CE'(coeff_y);
    ex_w = CE'(coeff_w);
    ex_o = CE'(offsets);
    tx = lane_term(ex_x, m0_r[M-1], m1_r[M-1], m2_r[M-1]);
    ty = lane_term(ex_y, m0_r[M-1], m1_r[M-1], m2_r[M-1]);
    tw = lane_term(ex_w, m0_r[M-1], m1_r[M-1], m2_r[M-1]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      off_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + NB'(1);
        if (cnt_r == NB'(M - 1)) begin
          busy_r <= 1'b0;
          off_r  <= 1'b1;
        end
      end else if (off_r) begin
        off_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      m0_r <= M'(col);
      m1_r <= M'(row);
      m2_r <= M'(depth);
    end else if (busy_r) begin
      m0_r <= m0_r << 1;
      m1_r <= m1_r << 1;
      m2_r <= m2_r << 1;
      // The top bit carries negative weight for the signed depth.
      if (cnt_r == '0) begin
        acc_x_r <= -tx;
        acc_y_r <= -ty;
        acc_w_r <= -tw;
      end else begin
        acc_x_r <= (acc_x_r <<< 1) + tx;
        acc_y_r <= (acc_y_r <<< 1) + ty;
        acc_w_r <= (acc_w_r <<< 1) + tw;
      end
    end else if (off_r) begin
      acc_x_r <= acc_x_r + (fld(ex_o, 0) <<< 4);
      acc_y_r <= acc_y_r + (fld(ex_o, 1) <<< 4);
      acc_w_r <= acc_w_r + (fld(ex_o, 2) <<< 4);
    end
  end

  assign done  = done_r;
  assign sum_x = acc_x_r;
  assign sum_y = acc_y_r;
  assign sum_w = acc_w_r;

endmodule

FILE: rtl/core/rgp_div.sv
// Two-lane restoring divider sharing one denominator, with Q16.16 saturation.
// Depends on rgp_pkg.
`timescale 1ns / 1ps
module rgp_div #(
  parameter int SW = 42
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 frac,
  input  logic signed [SW-1:0] num_x,
  input  logic signed [SW-1:0] num_y,
  input  logic signed [SW-1:0] den,
  output logic                 done,
  output logic [31:0]          res_x,
  output logic [31:0]          res_y
);
  import rgp_pkg::*;

  localparam int NW = SW + 16;
  localparam int NB = $clog2(NW + 1);

  logic [NW-1:0] nx_r, ny_r;
  logic [SW-1:0] d_r, rx_r, ry_r, ax, ay, ad;
  logic [32:0]   qx_r, qy_r;
  logic          ovx_r, ovy_r, negx_r, negy_r, frac_r, busy_r, done_r;
  logic [NB-1:0] cnt_r;
  logic [SW:0]   sx, sy;
  logic          bx, by;

  function automatic logic [31:0] sat_out(input logic [32:0] m, input logic ov,
                                          input logic neg, input logic fr);
    logic [31:0] nm;
    nm = ~m[31:0] + 32'd1;
    if (fr) begin
      if (neg) return (ov || m > 33'h080000000) ? 32'h80000000 : nm;
      return (ov || m > 33'h07FFFFFFF) ? 32'h7FFFFFFF : m[31:0];
    end
    if (neg) return (ov || m > 33'd32768) ? 32'h80000000 : {nm[15:0], 16'd0};
    return (ov || m > 33'd32767) ? 32'h7FFF0000 : {m[15:0], 16'd0};
  endfunction

  always_comb begin
    ax = num_x[SW-1] ? (~num_x + SW'(1)) : num_x;
    ay = num_y[SW-1] ? (~num_y + SW'(1)) : num_y;
    ad = den[SW-1] ? (~den + SW'(1)) : den;
    sx = {rx_r, nx_r[NW-1]};
    bx = (sx >= {1'b0, d_r});
    if (bx) sx = sx - {1'b0, d_r};
    sy = {ry_r, ny_r[NW-1]};
    by = (sy >= {1'b0, d_r});
    if (by) sy = sy - {1'b0, d_r};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + NB'(1);
        if (cnt_r == NB'(NW - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      nx_r   <= frac ? {ax, 16'd0} : {16'd0, ax};
      ny_r   <= frac ? {ay, 16'd0} : {16'd0, ay};
      d_r    <= ad;
      rx_r   <= '0;
      ry_r   <= '0;
      qx_r   <= '0;
      qy_r   <= '0;
      ovx_r  <= 1'b0;
      ovy_r  <= 1'b0;
      negx_r <= num_x[SW-1] ^ den[SW-1];
      negy_r <= num_y[SW-1] ^ den[SW-1];
      frac_r <= frac;
    end else if (busy_r) begin
      nx_r  <= nx_r << 1;
      ny_r  <= ny_r << 1;
      rx_r  <= sx[SW-1:0];
      ry_r  <= sy[SW-1:0];
      // Quotient bits beyond 33 only matter as an overflow mark.
      qx_r  <= {qx_r[31:0], bx};
      qy_r  <= {qy_r[31:0], by};
      ovx_r <= ovx_r | qx_r[32];
      ovy_r <= ovy_r | qy_r[32];
    end
  end

  assign done  = done_r;
  assign res_x = sat_out(qx_r, ovx_r, negx_r, frac_r);
  assign res_y = sat_out(qy_r, ovy_r, negy_r, frac_r);

endmodule

FILE: tb/range_grid_projection_checker.sv
// Scoreboard for the range grid projection unit: tracks configuration writes and the
// grid position, predicts each projected beat and compares it with the output channel.
// Depends on rgp_pkg for the register indexes and the mode bit positions.
`timescale 1ns / 1ps
module range_grid_projection_checker #(
  parameter int MAX_GRID_DIM = 4096,
  parameter int COEFF_WIDTH  = 20
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_stall,
  input  logic signed [15:0]        in_depth_sample,
  input  logic                      out_valid,
  input  logic                      out_stall,
  input  logic signed [31:0]        out_x_out,
  input  logic signed [31:0]        out_y_out,
  input  logic                      out_zero_denominator,
  input  logic                      out_last_in_frame,
  input  logic                      cfg_we,
  input  logic [3:0]                cfg_index,
  input  logic [rgp_pkg::REG_W-1:0] cfg_data,
  output int                        fail_count,
  output int                        pending,
  output int                        checked
);
  import rgp_pkg::*;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic        zden;
    logic        last;
  } proj_beat_t;

  proj_beat_t projected_q[$];

  logic [REG_W-1:0] coeff_x, coeff_y, coeff_w, offsets;
  logic [12:0]      grid_w, grid_h;
  logic [15:0]      steps;
  logic [1:0]       mode;
  int               col, row;

  function automatic longint slot_coeff(logic [REG_W-1:0] r, int k);
    logic signed [COEFF_WIDTH-1:0] f;
    f = r[k*COEFF_WIDTH +: COEFF_WIDTH];
    return longint'(f);
  endfunction

  function automatic longint row_sum(logic [REG_W-1:0] r, int slot, longint c, longint rw,
                                     longint d);
    return c * slot_coeff(r, 0) * 16 + rw * slot_coeff(r, 1) * 16 + d * slot_coeff(r, 2)
           + slot_coeff(offsets, slot) * 16;
  endfunction

  function automatic longint sat32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  function automatic longint divide_q16(longint num, longint den, bit as_int);
    longint q;
    if (as_int) begin
      q = num / den;
      if (q > 32767) q = 32767;
      if (q < -32768) q = -32768;
      return q * 65536;
    end
    return sat32((num * 65536) / den);
  endfunction

  function automatic int clamp_dim(logic [12:0] d);
    if (d == 0) return 1;
    if (d > MAX_GRID_DIM) return MAX_GRID_DIM;
    return d;
  endfunction

  task automatic project_sample(logic signed [15:0] depth);
    int         w, h, xs, ys;
    longint     sx, sy, sw, xr, yr;
    bit         ortho, as_int;
    proj_beat_t b;
    w = clamp_dim(grid_w);
    h = clamp_dim(grid_h);
    xs = (steps[7:0] == 0) ? 1 : steps[7:0];
    ys = (steps[15:8] == 0) ? 1 : steps[15:8];
    ortho = mode[MODE_ORTHO_BIT];
    as_int = mode[MODE_INT_BIT];
    if (col < w && row < h && col % xs == 0 && row % ys == 0) begin
      sx = row_sum(coeff_x, 0, col, row, depth);
      sy = row_sum(coeff_y, 1, col, row, depth);
      b.zden = 1'b0;
      if (ortho) begin
        xr = sat32(sx);
        yr = sat32(sy);
        if (as_int) begin
          xr = (xr / 65536) * 65536;
          yr = (yr / 65536) * 65536;
        end
      end else begin
        sw = row_sum(coeff_w, 2, col, row, depth);
        if (sw == 0) begin
          xr = 0;
          yr = 0;
          b.zden = 1'b1;
        end else begin
          xr = divide_q16(sx, sw, as_int);
          yr = divide_q16(sy, sw, as_int);
        end
      end
      b.x = xr[31:0];
      b.y = yr[31:0];
      b.last = (col == ((w - 1) / xs) * xs) && (row == ((h - 1) / ys) * ys);
      projected_q.push_back(b);
    end
    // Counters wrap at the row and frame end, also when they stand beyond a shrunk grid.
    if (col + 1 >= w) begin
      col = 0;
      row = (row + 1 >= h) ? 0 : row + 1;
    end else begin
      col = col + 1;
    end
  endtask

  task automatic compare_beat();
    proj_beat_t b;
    checked++;
    if (projected_q.size() == 0) begin
      $error("output beat with no projection pending");
      fail_count++;
      return;
    end
    b = projected_q.pop_front();
    if (out_x_out !== b.x) begin
      $error("x_out mismatch: expected %0d, got %0d", $signed(b.x), out_x_out);
      fail_count++;
    end
    if (out_y_out !== b.y) begin
      $error("y_out mismatch: expected %0d, got %0d", $signed(b.y), out_y_out);
      fail_count++;
    end
    if (out_zero_denominator !== b.zden) begin
      $error("zero_denominator mismatch: expected %0d, got %0d", b.zden,
             out_zero_denominator);
      fail_count++;
    end
    if (out_last_in_frame !== b.last) begin
      $error("last_in_frame mismatch: expected %0d, got %0d", b.last, out_last_in_frame);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      coeff_x = 60'd4096;
      coeff_y = 60'd4294967296;
      coeff_w = '0;
      offsets = 60'd4398046511104;
      grid_w = 13'd256;
      grid_h = 13'd256;
      steps = 16'd257;
      mode = '0;
      col = 0;
      row = 0;
      projected_q.delete();
      fail_count = 0;
      checked = 0;
      pending = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_COEFF_X: coeff_x = cfg_data;
          REG_COEFF_Y: coeff_y = cfg_data;
          REG_COEFF_W: coeff_w = cfg_data;
          REG_OFFSETS: offsets = cfg_data;
          REG_GRID_W:  grid_w = cfg_data[12:0];
          REG_GRID_H:  grid_h = cfg_data[12:0];
          REG_STEPS:   steps = cfg_data[15:0];
          REG_MODE:    mode = cfg_data[1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) project_sample(in_depth_sample);
      if (out_valid && !out_stall) compare_beat();
      pending = projected_q.size();
    end
  end

endmodule

FILE: tb/testbench.sv
// Top of the range grid projection testbench: clock, reset, stimulus and verdict.
// Depends on rgp_pkg, range_grid_projection_unit and range_grid_projection_checker.
`timescale 1ns / 1ps
module testbench;
  import rgp_pkg::*;

  localparam int CW         = 20;
  localparam int IDLE_LIMIT = 20000;
  localparam int DRAIN      = 150;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic signed [15:0] in_depth_sample = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [31:0] out_x_out, out_y_out;
  logic               out_zero_denominator, out_last_in_frame;
  logic               cfg_we = 1'b0;
  logic [3:0]         cfg_index = '0;
  logic [REG_W-1:0]   cfg_data = '0;
  int                 fail_count, pending, checked;
  int                 samples_sent = 0;
  int                 idle_cycles = 0;
  bit                 stim_done = 1'b0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  range_grid_projection_unit #(.MAX_GRID_DIM(4096), .COEFF_WIDTH(CW)) DUT (.*);

  range_grid_projection_checker #(.MAX_GRID_DIM(4096), .COEFF_WIDTH(CW)) u_checker (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // Receiver back-pressure: bursts of stall, runs of free flow, a few long holds.
  initial begin
    int len;
    forever begin
      len = $urandom_range(0, 99);
      if (len < 20) begin
        out_stall <= 1'b0;
        repeat ($urandom_range(50, 300)) @(posedge clk);
      end else begin
        out_stall <= 1'b1;
        repeat ((len < 95) ? $urandom_range(1, 4) : $urandom_range(20, 60)) @(posedge clk);
        out_stall <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  end

  always @(negedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we)
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  task automatic send_sample(logic signed [15:0] depth);
    int  gap;
    bit  taken;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_depth_sample <= depth;
    do begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end while (!taken);
    samples_sent++;
  endtask

  // Register writes go out on consecutive edges; the caller drops the enable.
  task automatic put_reg(logic [3:0] idx, logic [REG_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
  endtask

  // Unused samples leave no result, so wait out a full sample time after the last beat.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic logic [REG_W-1:0] pack_coeffs(int a, int b, int c);
    logic [CW-1:0] fa, fb, fc;
    fa = a[CW-1:0];
    fb = b[CW-1:0];
    fc = c[CW-1:0];
    return {fc, fb, fa};
  endfunction

  function automatic int small_coeff();
    return int'($urandom_range(0, 8191)) - 4096;
  endfunction

  function automatic logic [REG_W-1:0] wide_random();
    return REG_W'({$urandom, $urandom});
  endfunction

  function automatic logic [REG_W-1:0] grid_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return REG_W'($urandom_range(1, 12));
    if (r < 85) return '0;
    if (r < 90) return REG_W'(4096);
    if (r < 95) return REG_W'(8191);
    return wide_random();
  endfunction

  function automatic logic [7:0] step_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 85) return 8'($urandom_range(1, 4));
    if (r < 92) return 8'd0;
    return 8'd255;
  endfunction

  task automatic random_setup(output bit zero_heavy);
    int kind;
    logic [REG_W-1:0] upper;
    kind = $urandom_range(0, 3);
    zero_heavy = (kind >= 2);
    upper = $urandom_range(0, 3) == 0 ? wide_random() : '0;
    if (kind == 0) begin
      put_reg(REG_COEFF_X, wide_random());
      put_reg(REG_COEFF_Y, wide_random());
      put_reg(REG_COEFF_W, wide_random());
      put_reg(REG_OFFSETS, wide_random());
    end else begin
      put_reg(REG_COEFF_X, pack_coeffs(small_coeff(), small_coeff(), small_coeff()));
      put_reg(REG_COEFF_Y, pack_coeffs(small_coeff(), small_coeff(), small_coeff()));
      // A depth-only denominator row is zero exactly when the depth is zero.
      if (kind == 2)
        put_reg(REG_COEFF_W, '0);
      else if (kind == 3)
        put_reg(REG_COEFF_W, pack_coeffs(0, 0, small_coeff() | 1));
      else
        put_reg(REG_COEFF_W, pack_coeffs(small_coeff(), small_coeff(), small_coeff()));
      put_reg(REG_OFFSETS, pack_coeffs(small_coeff(), small_coeff(),
                                       kind >= 2 ? 0 : small_coeff()));
    end
    put_reg(REG_GRID_W, grid_dim());
    put_reg(REG_GRID_H, grid_dim());
    put_reg(REG_STEPS, {upper[REG_W-1:16], step_byte(), step_byte()});
    put_reg(REG_MODE, {upper[REG_W-1:2], 2'($urandom_range(0, 3))});
    if ($urandom_range(0, 3) == 0) put_reg(4'($urandom_range(8, 15)), wide_random());
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic signed [15:0] corner_depths[8];
    bit zero_heavy;
    int phases;
    corner_depths = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001,
                      16'sh0001, 16'sh5555, -16'sh5556, 16'sh0010};
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset configuration: identity-like perspective view.
    foreach (corner_depths[i]) send_sample(corner_depths[i]);
    settle();

    // Every mode on a tiny grid with the extreme coefficients, each with a zero depth last.
    for (int m = 0; m < 4; m++) begin
      put_reg(REG_COEFF_X, pack_coeffs(524287, -524288, 524287));
      put_reg(REG_COEFF_Y, pack_coeffs(-524288, 524287, -524288));
      put_reg(REG_COEFF_W, pack_coeffs(m, 0, 1));
      put_reg(REG_OFFSETS, pack_coeffs(-524288, 524287, 0));
      put_reg(REG_GRID_W, REG_W'(3));
      put_reg(REG_GRID_H, REG_W'(2));
      put_reg(REG_STEPS, REG_W'(16'h0102));
      put_reg(REG_MODE, REG_W'(m));
      cfg_we <= 1'b0;
      send_sample(16'sh7fff);
      send_sample(-16'sh8000);
      send_sample(16'sh0000);
      settle();
    end

    phases = 0;
    while (samples_sent < 1820) begin
      random_setup(zero_heavy);
      repeat ($urandom_range(40, 110)) begin
        if (zero_heavy && $urandom_range(0, 3) == 0)
          send_sample('0);
        else
          send_sample(16'($urandom));
      end
      settle();
      phases++;
    end

    stim_done = 1'b1;
    $display("covered %0d samples over %0d configurations, %0d projected beats checked",
             samples_sent, phases + 5, checked);
    $display("all four projection modes, zero denominators, grid and step extremes");
    if (fail_count == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule
